### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the level meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### sv/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg
// Types and constants shared by the RMS level meter modules.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RMS_W     = 24;
  localparam int DB_W      = 16;
  localparam int NB_W      = 12;
  localparam int BLK_W     = NB_W + 1;
  localparam int SQ_W      = 48;
  localparam int SQ_STEPS  = SQ_W / 2;
  localparam int FRAC_W    = 24;
  localparam int MANT_W    = 32;
  localparam int ACC_W     = 29;
  localparam int DPROD_W   = 56;

  localparam logic [26:0] DB_PER_OCT = 27'd101008905;
  localparam logic [16:0] DB_SAT     = 17'd32768;
  localparam logic [15:0] DB_FLOOR   = 16'h8000;

  localparam logic [1:0] CFG_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_BYPASS     = 2'd1;
  localparam logic [1:0] CFG_NUM_BLOCKS = 2'd2;

  typedef struct packed {
    logic                report;
    logic [SAMPLE_W-1:0] sample;
  } job_hdr_t;

endpackage

### sv/rlm_fifo.sv
// ----------------------------------------------------------------------------
// rlm_fifo
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(DEPTH))
  `ASSERT_IMPL(a_no_overflow, full, !push || pop)
  `ASSERT_IMPL(a_no_underflow, empty, !pop)

endmodule

### sv/rlm_front.sv
// ----------------------------------------------------------------------------
// rlm_front
// Sample intake: squares, accumulates, counts blocks, queues jobs.
// ----------------------------------------------------------------------------
module rlm_front
  import rlm_pkg::*;
#(
  parameter int BLOCK_SAMPLES = 128,
  parameter int SUM_W         = 50
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                cfg_enable,
  input  logic                cfg_bypass,
  input  logic [NB_W-1:0]     cfg_num_blocks,
  output logic                push_o,
  input  logic                full_i,
  output job_hdr_t            hdr_o,
  output logic [SUM_W-1:0]    sum_o,
  output logic [BLK_W-1:0]    blocks_o
);

  localparam int CNT_W = $clog2(BLOCK_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_SAMPLES - 1);

  logic                s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                s1_bypass_r;
  logic [30:0]         s1_sq_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NB_W-1:0]     blk_r, blk_nxt, blk_inc, target;
  logic signed [31:0]  sq_full;
  logic                take, block_end, report;

  assign in_ready = !s1_valid_r || !full_i;
  assign take     = in_valid && in_ready && cfg_enable;
  assign push_o   = s1_valid_r && !full_i;
  assign sq_full  = $signed(in_sample) * $signed(in_sample);

  assign sum_add   = sum_r + SUM_W'(s1_sq_r);
  assign blk_inc   = blk_r + 1'b1;
  assign target    = (cfg_num_blocks == '0) ? NB_W'(1) : cfg_num_blocks;
  assign block_end = !s1_bypass_r && (cnt_r == CNT_LAST);
  assign report    = block_end && ((blk_inc >= target) || (blk_inc == '0));

  assign hdr_o.report = report;
  assign hdr_o.sample = s1_sample_r;
  assign sum_o        = sum_add;
  assign blocks_o     = (blk_inc == '0) ? BLK_W'(1 << NB_W) : {1'b0, blk_inc};

  always_comb begin
    s1_valid_nxt = take ? 1'b1 : (push_o ? 1'b0 : s1_valid_r);
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    blk_nxt = blk_r;
    if (push_o && !s1_bypass_r) begin
      sum_nxt = sum_add;
      cnt_nxt = block_end ? '0 : cnt_r + 1'b1;
      if (block_end) begin
        blk_nxt = blk_inc;
      end
      if (report) begin
        sum_nxt = '0;
        blk_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sample_r <= in_sample;
      s1_bypass_r <= cfg_bypass;
      s1_sq_r     <= sq_full[30:0];
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      sum_r      <= '0;
      cnt_r      <= '0;
      blk_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      blk_r      <= blk_nxt;
    end
  end

endmodule

### sv/rlm_back.sv
// ----------------------------------------------------------------------------
// rlm_back
// Report engine: divide, square root, log2 and dB scaling, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlm_back
  import rlm_pkg::*;
#(
  parameter int BLOCK_SAMPLES = 128,
  parameter int SUM_W         = 50
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty_i,
  output logic                pop_o,
  input  job_hdr_t            hdr_i,
  input  logic [SUM_W-1:0]    sum_i,
  input  logic [BLK_W-1:0]    blocks_i,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample_out,
  output logic                out_measure_valid,
  output logic [RMS_W-1:0]    out_rms_q8,
  output logic [DB_W-1:0]     out_dbfs_q8
);

  localparam int DIV_W = SUM_W + 16;
  localparam int N_W   = $clog2((1 << NB_W) * BLOCK_SAMPLES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SQRT, ST_NORM, ST_LOGM, ST_LOGS, ST_DBA, ST_DBM, ST_DBS, ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [DIV_W-1:0]    dvd_r, dvd_nxt;
  logic [N_W-1:0]      rem_r, rem_nxt, dn_r, dn_nxt;
  logic [SQ_W-1:0]     quo_r, quo_nxt, sv_r, sv_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [MANT_W-1:0]   m_r, m_nxt;
  logic [4:0]          e_r, e_nxt;
  logic [63:0]         prod_r, prod_nxt;
  logic [FRAC_W-1:0]   f_r, f_nxt;
  logic [ACC_W-1:0]    a_r, a_nxt;
  logic [DPROD_W-1:0]  dprod_r, dprod_nxt;
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [RMS_W-1:0]    rms_r, rms_nxt;
  logic [DB_W-1:0]     db_r, db_nxt;

  logic                ov_r, ov_nxt, om_r, om_nxt;
  logic [SAMPLE_W-1:0] os_r, os_nxt;
  logic [RMS_W-1:0]    orms_r, orms_nxt;
  logic [DB_W-1:0]     odb_r, odb_nxt;

  logic                can_out, ge;
  logic [N_W:0]        trial;
  logic [SQ_W-1:0]     sq_tmp;
  logic [32:0]         lt;
  logic [ACC_W-1:0]    a_hi;
  logic [DPROD_W:0]    rnd;
  logic [16:0]         mag;

  assign can_out = !ov_r || out_ready;
  assign pop_o   = (state_r == ST_IDLE) && !empty_i && can_out;

  assign trial  = {rem_r, dvd_r[DIV_W-1]};
  assign ge     = trial >= {1'b0, dn_r};
  assign sq_tmp = res_r + bit_r;
  assign lt     = prod_r[63:31];
  assign a_hi   = {5'd23 - e_r, {FRAC_W{1'b0}}};
  assign rnd    = {1'b0, dprod_r} + (DPROD_W + 1)'(64'd1 << 39);
  assign mag    = (rnd[DPROD_W:40] > DB_SAT) ? DB_SAT : rnd[56:40];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;   dvd_nxt = dvd_r;   rem_nxt = rem_r;   dn_nxt = dn_r;
    quo_nxt = quo_r;   sv_nxt = sv_r;     res_nxt = res_r;   bit_nxt = bit_r;
    m_nxt = m_r;       e_nxt = e_r;       prod_nxt = prod_r; f_nxt = f_r;
    a_nxt = a_r;       dprod_nxt = dprod_r;
    smp_nxt = smp_r;   rms_nxt = rms_r;   db_nxt = db_r;
    ov_nxt = (ov_r && out_ready) ? 1'b0 : ov_r;
    om_nxt = om_r;     os_nxt = os_r;     orms_nxt = orms_r; odb_nxt = odb_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_o) begin
          if (hdr_i.report) begin
            smp_nxt   = hdr_i.sample;
            dvd_nxt   = {sum_i, 16'b0};
            rem_nxt   = '0;
            quo_nxt   = '0;
            dn_nxt    = N_W'(blocks_i * BLOCK_SAMPLES);
            cnt_nxt   = 7'(DIV_W);
            state_nxt = ST_DIV;
          end else begin
            ov_nxt   = 1'b1;
            os_nxt   = hdr_i.sample;
            om_nxt   = 1'b0;
            orms_nxt = '0;
            odb_nxt  = '0;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? N_W'(trial - {1'b0, dn_r}) : trial[N_W-1:0];
        quo_nxt = {quo_r[SQ_W-2:0], ge};
        dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          sv_nxt    = quo_nxt;
          res_nxt   = '0;
          bit_nxt   = SQ_W'(1) << (SQ_W - 2);
          cnt_nxt   = 7'(SQ_STEPS);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sv_r >= sq_tmp) begin
          sv_nxt  = sv_r - sq_tmp;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          rms_nxt = res_nxt[RMS_W-1:0];
          m_nxt   = {res_nxt[RMS_W-1:0], 8'b0};
          e_nxt   = 5'd23;
          if (res_nxt[RMS_W-1:0] == '0) begin
            db_nxt    = DB_FLOOR;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (m_r[MANT_W-1]) begin
          f_nxt     = '0;
          cnt_nxt   = 7'(FRAC_W);
          state_nxt = ST_LOGM;
        end else begin
          m_nxt = {m_r[MANT_W-2:0], 1'b0};
          e_nxt = e_r - 1'b1;
        end
      end
      ST_LOGM: begin
        prod_nxt  = m_r * m_r;
        state_nxt = ST_LOGS;
      end
      ST_LOGS: begin
        m_nxt     = lt[32] ? lt[32:1] : lt[31:0];
        f_nxt     = {f_r[FRAC_W-2:0], lt[32]};
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = (cnt_r == 7'd1) ? ST_DBA : ST_LOGM;
      end
      ST_DBA: begin
        a_nxt     = (a_hi >= ACC_W'(f_r)) ? a_hi - ACC_W'(f_r) : '0;
        state_nxt = ST_DBM;
      end
      ST_DBM: begin
        dprod_nxt = a_r * DB_PER_OCT;
        state_nxt = ST_DBS;
      end
      ST_DBS: begin
        db_nxt    = 16'(17'h10000 - mag);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (can_out) begin
          ov_nxt    = 1'b1;
          os_nxt    = smp_r;
          om_nxt    = 1'b1;
          orms_nxt  = rms_r;
          odb_nxt   = db_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    cnt_r <= cnt_nxt;   dvd_r <= dvd_nxt;   rem_r <= rem_nxt;   dn_r <= dn_nxt;
    quo_r <= quo_nxt;   sv_r <= sv_nxt;     res_r <= res_nxt;   bit_r <= bit_nxt;
    m_r <= m_nxt;       e_r <= e_nxt;       prod_r <= prod_nxt; f_r <= f_nxt;
    a_r <= a_nxt;       dprod_r <= dprod_nxt;
    smp_r <= smp_nxt;   rms_r <= rms_nxt;   db_r <= db_nxt;
    om_r <= om_nxt;     os_r <= os_nxt;     orms_r <= orms_nxt; odb_r <= odb_nxt;
  end

  assign out_valid         = ov_r;
  assign out_sample_out    = os_r;
  assign out_measure_valid = om_r;
  assign out_rms_q8        = orms_r;
  assign out_dbfs_q8       = odb_r;

  `ASSERT_IMPL(a_plain_beat_zero, ov_r && !om_r, orms_r == '0 && odb_r == '0)
  `ASSERT_IMPL(a_rms_range, ov_r && om_r, orms_r <= RMS_W'(1 << 23))

endmodule

### sv/rms_level_meter.sv
// ----------------------------------------------------------------------------
// rms_level_meter
// Streaming RMS and dBFS level meter for signed 16-bit audio.
// ----------------------------------------------------------------------------
// Samples enter on in_valid/in_ready; if enabled, each yields one beat on
// out_valid/out_ready carrying the sample unchanged. After num_blocks
// blocks of BLOCK_SAMPLES samples, that beat also carries measure_valid,
// the RMS (Q8) and the level in dBFS (Q8.8), and the running sum restarts.
// cfg_valid/cfg_ready writes enable (index 0), bypass (1), num_blocks (2);
// cfg_ready is always high. With enable low, samples are taken and dropped.
// A plain sample passes the front stage register, the queue and the
// output register; plain samples flow at one per cycle while the back
// end is idle and out_ready is high. After the queue pop, a report beat
// runs the divider, the square root, normalize, log2 (one 32x32 squaring
// per bit), scaling and the output load; a zero RMS skips normalize,
// log2 and scaling. The back end does one report at a time while a
// two-entry queue and the front stage keep taking samples until full.
// Reset empties the queue and clears the sum and counters; registers go to
// enable 1, bypass 0, num_blocks 1. A stalled out_ready holds the output
// register, then fills the queue, then drops in_ready.
// ----------------------------------------------------------------------------
module rms_level_meter
  import rlm_pkg::*;
#(
  parameter int BLOCK_SAMPLES = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_sample_out,
  output logic                out_measure_valid,
  output logic [RMS_W-1:0]    out_rms_q8,
  output logic [DB_W-1:0]     out_dbfs_q8,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [NB_W-1:0]     cfg_data
);

  localparam int SUM_W = 31 + NB_W + $clog2(BLOCK_SAMPLES);
  localparam int JOB_W = $bits(job_hdr_t) + SUM_W + BLK_W;

  logic             enable_r, bypass_r;
  logic [NB_W-1:0]  num_blocks_r;
  logic             push, full, pop, empty;
  job_hdr_t         hdr_in, hdr_out;
  logic [SUM_W-1:0] sum_in, sum_out;
  logic [BLK_W-1:0] blk_in, blk_out;
  logic [JOB_W-1:0] job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      bypass_r     <= 1'b0;
      num_blocks_r <= NB_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:     enable_r     <= cfg_data[0];
        CFG_BYPASS:     bypass_r     <= cfg_data[0];
        CFG_NUM_BLOCKS: num_blocks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rlm_front #(.BLOCK_SAMPLES(BLOCK_SAMPLES), .SUM_W(SUM_W)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample,
    .cfg_enable(enable_r), .cfg_bypass(bypass_r), .cfg_num_blocks(num_blocks_r),
    .push_o(push), .full_i(full), .hdr_o(hdr_in), .sum_o(sum_in), .blocks_o(blk_in)
  );

  rlm_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
    .clk, .rst_n, .push, .din({hdr_in, sum_in, blk_in}), .full,
    .pop, .dout(job_out), .empty
  );

  assign {hdr_out, sum_out, blk_out} = job_out;

  rlm_back #(.BLOCK_SAMPLES(BLOCK_SAMPLES), .SUM_W(SUM_W)) u_back (
    .clk, .rst_n, .empty_i(empty), .pop_o(pop), .hdr_i(hdr_out), .sum_i(sum_out),
    .blocks_i(blk_out), .out_valid, .out_ready, .out_sample_out, .out_measure_valid,
    .out_rms_q8, .out_dbfs_q8
  );

endmodule

### verif/rms_level_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_level_meter_tb
// Self-checking testbench for the streaming RMS / dBFS level meter.
// ----------------------------------------------------------------------------
// A directed table covers pass-through, full scale, silence, bypass,
// disable, num_blocks 0 and 4095 and a lowered num_blocks. Random phases
// with random register settings follow. Every accepted sample runs through
// a local meter model and each output beat is compared with the oldest
// expected beat. Both sides idle at random, and once the output side holds
// off long enough to back the meter up.
// ----------------------------------------------------------------------------
module rms_level_meter_tb;
  import rlm_pkg::*;

  localparam int          BLK        = 128;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam int          SETTLE     = 300;
  localparam int          RAND_ITEMS = 820;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                measure;
    logic [RMS_W-1:0]    rms;
    logic [DB_W-1:0]     dbfs;
  } level_beat_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [11:0] data;
    logic [15:0] smp;
    int          reps;
    bit          typed;
    level_beat_t want;
  } stim_row_t;

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_ready = 0;
  logic [SAMPLE_W-1:0] out_sample_out;
  logic                out_measure_valid;
  logic [RMS_W-1:0]    out_rms_q8;
  logic [DB_W-1:0]     out_dbfs_q8;
  logic                cfg_valid = 0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [NB_W-1:0]     cfg_data = '0;

  // meter model state
  bit                 en_model;
  bit                 byp_model;
  logic [11:0]        m_num_blocks;
  longint unsigned    m_square_sum;
  int unsigned        m_in_block;
  int unsigned        m_blocks_done;

  level_beat_t pending_beats[$];
  stim_row_t   dir_rows[$];
  int          errors = 0;
  bit          calm = 0;
  bit          hold_req = 0;

  rms_level_meter #(.BLOCK_SAMPLES(BLK)) DUT (.*);

  always #1 clk = ~clk;

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DB_W-1:0] level_dbfs(logic [RMS_W-1:0] rms);
    int unsigned     e;
    longint unsigned m, f, a, mag;
    if (rms == 0) return DB_FLOOR;
    e = 0;
    while (e < 31 && (rms >> (e + 1)) != 0) e++;
    m = longint'(rms) << (31 - e);
    f = 0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      f <<= 1;
      if (m >= (64'd1 << 32)) begin
        f |= 1;
        m >>= 1;
      end
    end
    a = longint'(23 - (e > 23 ? 23 : e)) << 24;
    a = (a >= f) ? a - f : 0;
    mag = (a * longint'(DB_PER_OCT) + (64'd1 << 39)) >> 40;
    if (mag > 32768) mag = 32768;
    return DB_W'(64'h10000 - mag);
  endfunction

  function automatic bit meter_step(logic [15:0] smp, output level_beat_t r);
    longint          s, n, qh, rem, q;
    int unsigned     tgt;
    logic [RMS_W-1:0] rms;
    r = '{smp, 1'b0, '0, '0};
    if (!en_model) return 0;
    if (byp_model) return 1;
    s = longint'($signed(smp));
    m_square_sum += longint'(s * s);
    m_in_block++;
    if (m_in_block < BLK) return 1;
    m_in_block = 0;
    m_blocks_done = (m_blocks_done + 1) & 12'hFFF;
    tgt = (m_num_blocks != 0) ? m_num_blocks : 1;
    if (m_blocks_done >= tgt || m_blocks_done == 0) begin
      n = longint'(m_blocks_done != 0 ? m_blocks_done : 4096) * BLK;
      qh = m_square_sum / n;
      rem = m_square_sum % n;
      q = (qh << 16) + ((rem << 16) / n);
      rms = RMS_W'(int_sqrt(q));
      r.measure = 1;
      r.rms = rms;
      r.dbfs = level_dbfs(rms);
      m_square_sum = 0;
      m_blocks_done = 0;
    end
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic stim_row_t row_s(logic [15:0] smp, int reps, bit typed = 0,
                                      level_beat_t want = '0);
    stim_row_t r;
    r = '{0, '0, '0, smp, reps, typed, want};
    return r;
  endfunction

  function automatic stim_row_t row_c(logic [1:0] idx, logic [11:0] data);
    stim_row_t r;
    r = '{1, idx, data, '0, 0, 0, '0};
    return r;
  endfunction

  task automatic send_sample(logic [15:0] smp, bit typed = 0, level_beat_t want = '0);
    level_beat_t r;
    int          g;
    in_valid <= 1;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    if (meter_step(smp, r)) pending_beats.push_back(typed ? want : r);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_ENABLE:     en_model = data[0];
      CFG_BYPASS:     byp_model = data[0];
      CFG_NUM_BLOCKS: m_num_blocks = data;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom);
    if (r < 70) return 16'($signed($urandom_range(0, 255)) - 128);
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return 16'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  // output side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 99) < 3) begin
        out_ready <= 0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    level_beat_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat sample=%h", $time, out_sample_out);
        errors++;
      end else begin
        exp_b = pending_beats.pop_front();
        if (out_sample_out !== exp_b.sample) begin
          $display("%0t: sample_out exp %h got %h", $time, exp_b.sample, out_sample_out);
          errors++;
        end
        if (out_measure_valid !== exp_b.measure) begin
          $display("%0t: measure_valid exp %b got %b", $time, exp_b.measure,
                   out_measure_valid);
          errors++;
        end
        if (out_rms_q8 !== exp_b.rms) begin
          $display("%0t: rms_q8 exp %h got %h", $time, exp_b.rms, out_rms_q8);
          errors++;
        end
        if (out_dbfs_q8 !== exp_b.dbfs) begin
          $display("%0t: dbfs_q8 exp %h got %h", $time, exp_b.dbfs, out_dbfs_q8);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    int        sent, n;
    en_model = 1;
    byp_model = 0;
    m_num_blocks = 1;
    m_square_sum = 0;
    m_in_block = 0;
    m_blocks_done = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    repeat (SETTLE) @(posedge clk);

    dir_rows.push_back(row_s(16'h0000, 1, 1, '{16'h0000, 1'b0, '0, '0}));
    dir_rows.push_back(row_s(16'h7FFF, 1, 1, '{16'h7FFF, 1'b0, '0, '0}));
    dir_rows.push_back(row_s(16'h8000, 1, 1, '{16'h8000, 1'b0, '0, '0}));
    dir_rows.push_back(row_s(16'h0001, 1, 1, '{16'h0001, 1'b0, '0, '0}));
    dir_rows.push_back(row_s(16'hFFFF, 1, 1, '{16'hFFFF, 1'b0, '0, '0}));
    dir_rows.push_back(row_s(16'h5A5A, BLK - 5));
    // silence, then full scale
    dir_rows.push_back(row_s(16'h0000, BLK, 1, '{16'h0000, 1'b1, '0, DB_FLOOR}));
    dir_rows.push_back(row_s(16'h8000, BLK, 1, '{16'h8000, 1'b1, 24'h800000, '0}));
    dir_rows.push_back(row_c(CFG_BYPASS, 12'd1));
    dir_rows.push_back(row_s(16'h1234, 3, 1, '{16'h1234, 1'b0, '0, '0}));
    dir_rows.push_back(row_c(CFG_BYPASS, 12'd0));
    dir_rows.push_back(row_c(CFG_ENABLE, 12'd0));
    dir_rows.push_back(row_s(16'h7FFF, 3));
    dir_rows.push_back(row_c(CFG_ENABLE, 12'd1));
    dir_rows.push_back(row_c(CFG_NUM_BLOCKS, 12'd0));
    dir_rows.push_back(row_s(16'hA5A5, BLK));
    // lowered num_blocks while three blocks are already counted
    dir_rows.push_back(row_c(CFG_NUM_BLOCKS, 12'd4095));
    dir_rows.push_back(row_s(16'h0100, 3 * BLK));
    dir_rows.push_back(row_c(CFG_NUM_BLOCKS, 12'd1));
    dir_rows.push_back(row_s(16'h0100, BLK));
    dir_rows.push_back(row_c(CFG_UNUSED, 12'hFFF));
    dir_rows.push_back(row_c(CFG_NUM_BLOCKS, 12'd1));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.idx, row.data);
      end else begin
        for (int k = 0; k < row.reps; k++)
          send_sample(row.smp, row.typed && k == row.reps - 1, row.want);
      end
    end

    sent = 0;
    for (int ph = 0; sent < RAND_ITEMS; ph++) begin
      drain();
      write_reg(CFG_ENABLE, 12'(ph == 0 || $urandom_range(0, 99) < 90));
      write_reg(CFG_BYPASS, 12'($urandom_range(0, 99) < 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: write_reg(CFG_NUM_BLOCKS, 12'd1);
        5, 6, 7:       write_reg(CFG_NUM_BLOCKS, 12'($urandom_range(2, 4)));
        8:             write_reg(CFG_NUM_BLOCKS, 12'd0);
        default:       write_reg(CFG_NUM_BLOCKS, 12'd4095);
      endcase
      calm = ($urandom_range(0, 3) == 0);
      if (ph == 0) begin
        calm = 0;
        hold_req = 1;
      end
      n = $urandom_range(64, 400);
      if (n > RAND_ITEMS - sent) n = RAND_ITEMS - sent;
      for (int k = 0; k < n; k++) begin
        send_sample(rand_sample());
        sent++;
      end
    end
    calm = 0;

    in_valid <= 0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
